// ===== src/pdh_pkg.sv =====
// Shared types and constants of the pair distance histogram.
`timescale 1ns / 1ps
package pdh_pkg;

    localparam int COORD_W = 16;   // coordinate width, fixed point
    localparam int COUNT_W = 32;   // histogram counter width
    localparam int RAD_W   = 34;   // squared distance, padded to an even width
    localparam int ROOT_W  = 17;   // integer square root of RAD_W bits
    localparam int REM_W   = 20;   // square root partial remainder
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int BIN_OUT_W = 6;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_W   = 3'd0,
        CFG_BOX_H   = 3'd1,
        CFG_RAD_MIN = 3'd2,
        CFG_RAD_MAX = 3'd3,
        CFG_RAD_STP = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_RUN     = 5'b00010,
        S_DRAIN   = 5'b00100,
        S_RO_RD   = 5'b01000,
        S_RO_WAIT = 5'b10000
    } t_state;

    // Square root pipeline status toward the top level.
    typedef struct packed {
        logic              valid;
        logic              busy;
        logic [ROOT_W-1:0] root;
    } t_sq_out;

endpackage

// ===== src/pdh_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module pdh_isqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [pdh_pkg::RAD_W-2:0] i_radicand,
    output pdh_pkg::t_sq_out         o_status
);
    import pdh_pkg::*;

    logic [ROOT_W-1:0] r_v;
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            logic              w_v;
            logic [REM_W-1:0]  w_rem;
            logic [ROOT_W-1:0] w_root;
            logic [RAD_W-1:0]  w_rad;
            logic [REM_W-1:0]  w_sh;
            logic [REM_W-1:0]  w_trial;

            if (k == 0) begin : g_first
                assign w_v    = i_valid;
                assign w_rem  = '0;
                assign w_root = '0;
                assign w_rad  = {1'b0, i_radicand};
            end else begin : g_next
                assign w_v    = r_v[k-1];
                assign w_rem  = r_rem[k-1];
                assign w_root = r_root[k-1];
                assign w_rad  = r_rad[k-1];
            end

            // Bring down the next two radicand bits and try root*4+1.
            assign w_sh    = {w_rem[REM_W-3:0], w_rad[RAD_W-1 -: 2]};
            assign w_trial = {1'b0, w_root, 2'b01};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else begin
                    r_v[k] <= w_v;
                end
                r_rad[k] <= {w_rad[RAD_W-3:0], 2'b00};
                if (w_sh >= w_trial) begin
                    r_rem[k]  <= w_sh - w_trial;
                    r_root[k] <= {w_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_sh;
                    r_root[k] <= {w_root[ROOT_W-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign o_status.valid = r_v[ROOT_W-1];
    assign o_status.busy  = |r_v;
    assign o_status.root  = r_root[ROOT_W-1];

endmodule

// ===== src/pair_distance_histogram.sv =====
// Top level of the pair distance histogram accumulator.
`timescale 1ns / 1ps
// Usage
//   Input channel (i_in_valid / o_in_stall): one transaction carries an operation,
//   a point (i_pos_x, i_pos_y, Q fixed point) and i_frame_end.
//   Load pairs the point with every point already stored in the current frame.
//   Read out returns NUM_BINS result transactions, bins in ascending order,
//   o_last_bin high on the final one. Clear zeroes the histogram.
//   Output channel (o_out_valid / i_out_stall): one registered slot; a stalled
//   result holds until taken.
//   Config channel (i_cfg_valid / o_cfg_ready): always ready; write only while idle.
// Throughput
//   A load with n stored points issues n pairs (one pair per cycle through
//   the point memory read port), then drains the distance, square root and
//   divide pipeline. A read out steps each bin through a read state and a
//   wait state on the histogram memory port, and waits while the receiver stalls.
//   Clear and an empty load complete without leaving idle.
// Reset
//   Synchronous, active low: histogram reads as zero (per-bin valid flags),
//   frame count zero, registers at their defaults. No clearing pass is needed.
module pair_distance_histogram #(
    parameter int MAX_POINTS = 256,
    parameter int NUM_BINS   = 64,
    parameter int FRAC_BITS  = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_operation,
    input  logic [pdh_pkg::COORD_W-1:0]     i_pos_x,
    input  logic [pdh_pkg::COORD_W-1:0]     i_pos_y,
    input  logic                            i_frame_end,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pdh_pkg::BIN_OUT_W-1:0]   o_bin_index,
    output logic [pdh_pkg::COUNT_W-1:0]     o_bin_count,
    output logic                            o_last_bin,
    // configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pdh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pdh_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import pdh_pkg::*;

    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int BW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int NBW = $clog2(NUM_BINS + 1);
    localparam int LW  = 10 + FRAC_BITS;                 // box length width
    localparam int WW  = (LW + 2 > 19) ? LW + 2 : 19;    // signed difference width
    localparam int LIMW = CFG_DAT_W + NBW;               // step * NUM_BINS
    localparam int DVW = ROOT_W + BW;                   // divider compare width

    // ---------------- configuration ----------------
    logic [9:0]           r_box_w, r_box_h;
    logic [CFG_DAT_W-1:0] r_rmin, r_rmax, r_rstep;
    logic [CFG_DAT_W-1:0] w_step;

    assign o_cfg_ready = 1'b1;
    assign w_step      = (r_rstep == '0) ? CFG_DAT_W'(1) : r_rstep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_w <= 10'd256;
            r_box_h <= 10'd256;
            r_rmin  <= '0;
            r_rmax  <= CFG_DAT_W'(8192);
            r_rstep <= CFG_DAT_W'(64);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BOX_W:   r_box_w <= i_cfg_data[9:0];
                CFG_BOX_H:   r_box_h <= i_cfg_data[9:0];
                CFG_RAD_MIN: r_rmin  <= i_cfg_data;
                CFG_RAD_MAX: r_rmax  <= i_cfg_data;
                CFG_RAD_STP: r_rstep <= i_cfg_data;
                default: ;   // unmapped index: drop
            endcase
        end
    end

    // ---------------- control ----------------
    t_state              r_state, n_state;
    logic [CW-1:0]       r_count;      // points stored in the current frame
    logic [CW-1:0]       r_n;          // pairs to issue for this load
    logic [CW-1:0]       r_rd_idx;
    logic [COORD_W-1:0]  r_nx, r_ny;   // point being paired
    logic [BW-1:0]       r_ro_bin;
    logic                w_accept;
    logic                w_issue;
    logic                w_pipe_busy;
    logic                w_slot_free;
    t_op                 w_op;

    assign w_op        = t_op'(i_operation);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_issue     = (r_state == S_RUN);
    assign w_slot_free = !o_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_op == OP_LOAD && r_count != '0) begin
                        n_state = S_RUN;
                    end else if (w_op == OP_READ) begin
                        n_state = S_RO_RD;
                    end
                end
            end
            S_RUN: begin
                if (r_rd_idx == r_n - CW'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!w_pipe_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_RO_RD: begin
                n_state = S_RO_WAIT;
            end
            S_RO_WAIT: begin
                if (w_slot_free) begin
                    n_state = (r_ro_bin == BW'(NUM_BINS - 1)) ? S_IDLE : S_RO_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_idx <= '0;
            r_ro_bin <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept && w_op == OP_LOAD) begin
                r_rd_idx <= '0;
                // Close the frame, or append while there is room.
                if (i_frame_end) begin
                    r_count <= '0;
                end else if (r_count < CW'(MAX_POINTS)) begin
                    r_count <= r_count + CW'(1);
                end
            end else if (w_issue) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            if (w_accept && w_op == OP_READ) begin
                r_ro_bin <= '0;
            end else if (r_state == S_RO_WAIT && w_slot_free) begin
                r_ro_bin <= r_ro_bin + BW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_op == OP_LOAD) begin
            r_nx <= i_pos_x;
            r_ny <= i_pos_y;
            r_n  <= r_count;
        end
    end

    // ---------------- point memory ----------------
    logic [2*COORD_W-1:0] r_pts [MAX_POINTS];
    logic [2*COORD_W-1:0] r_p1_pt;
    logic                 r_p1_v;

    always_ff @(posedge i_clk) begin
        // New point goes to slot r_count, never read during its own load.
        if (w_accept && w_op == OP_LOAD && !i_frame_end && r_count < CW'(MAX_POINTS)) begin
            r_pts[r_count[AW-1:0]] <= {i_pos_x, i_pos_y};
        end
        if (w_issue) begin
            r_p1_pt <= r_pts[r_rd_idx[AW-1:0]];
        end
    end

    // ---------------- distance pipeline ----------------
    logic                  r_p2_v, r_p3_v, r_p4_v;
    logic [COORD_W-1:0]    r_ax, r_ay;
    logic [2*COORD_W-1:0]  r_sx, r_sy;
    logic [2*COORD_W:0]    r_ss;
    logic [COORD_W-1:0]    w_ax, w_ay;

    function automatic logic [COORD_W-1:0] wrap_abs(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b,
        input logic [9:0]         box
    );
        logic signed [WW-1:0] d;
        logic signed [WW-1:0] len;
        logic signed [WW-1:0] d2;
        d   = $signed(WW'(a)) - $signed(WW'(b));
        len = $signed(WW'(box) << FRAC_BITS);
        d2  = d <<< 1;
        if (d2 >= len) begin
            d = d - len;
        end else if (d2 <= -len) begin
            d = d + len;
        end
        if (d < 0) begin
            d = -d;
        end
        return d[COORD_W-1:0];
    endfunction

    assign w_ax = wrap_abs(r_p1_pt[2*COORD_W-1 -: COORD_W], r_nx, r_box_w);
    assign w_ay = wrap_abs(r_p1_pt[COORD_W-1:0], r_ny, r_box_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
        end else begin
            r_p1_v <= w_issue;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
        end
        r_ax <= w_ax;
        r_ay <= w_ay;
        r_sx <= (2*COORD_W)'(r_ax) * (2*COORD_W)'(r_ax);
        r_sy <= (2*COORD_W)'(r_ay) * (2*COORD_W)'(r_ay);
        r_ss <= {1'b0, r_sx} + {1'b0, r_sy};
    end

    t_sq_out w_sq;

    pdh_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_p4_v),
        .i_radicand (r_ss),
        .o_status   (w_sq)
    );

    // ---------------- range check and bin divide ----------------
    logic                r_c_v, r_c_ok;
    logic [ROOT_W-1:0]   r_c_off;
    logic [LIMW-1:0]     w_limit;

    assign w_limit = LIMW'(w_step) * LIMW'(NUM_BINS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= w_sq.valid;
        end
        r_c_off <= w_sq.root - ROOT_W'(r_rmin);
        r_c_ok  <= (w_sq.root >= ROOT_W'(r_rmin)) && (w_sq.root < ROOT_W'(r_rmax))
                && (LIMW'(w_sq.root - ROOT_W'(r_rmin)) < w_limit);
    end

    logic [BW-1:0]     r_d_v;
    logic [BW-1:0]     r_d_ok;
    logic [ROOT_W-1:0] r_d_rem [BW];
    logic [BW-1:0]     r_d_q   [BW];

    genvar j;
    generate
        for (j = 0; j < BW; j++) begin : g_div
            logic              w_v, w_ok;
            logic [ROOT_W-1:0] w_rem;
            logic [BW-1:0]     w_q;
            logic [DVW-1:0]    w_den;

            if (j == 0) begin : g_first
                assign w_v   = r_c_v;
                assign w_ok  = r_c_ok;
                assign w_rem = r_c_off;
                assign w_q   = '0;
            end else begin : g_next
                assign w_v   = r_d_v[j-1];
                assign w_ok  = r_d_ok[j-1];
                assign w_rem = r_d_rem[j-1];
                assign w_q   = r_d_q[j-1];
            end

            assign w_den = DVW'(w_step) << (BW - 1 - j);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_d_v[j] <= 1'b0;
                end else begin
                    r_d_v[j] <= w_v;
                end
                r_d_ok[j] <= w_ok;
                if (DVW'(w_rem) >= w_den) begin
                    r_d_rem[j] <= w_rem - ROOT_W'(w_den);
                    r_d_q[j]   <= w_q | (BW'(1) << (BW - 1 - j));
                end else begin
                    r_d_rem[j] <= w_rem;
                    r_d_q[j]   <= w_q;
                end
            end
        end
    endgenerate

    // ---------------- histogram memory, read-modify-write ----------------
    logic [COUNT_W-1:0] r_hist [NUM_BINS];
    logic [NUM_BINS-1:0] r_hv;          // bin written since last clear
    logic [COUNT_W-1:0] r_hq;
    logic               r_hv_q;
    logic               r_hw_v;
    logic [BW-1:0]      r_hw_bin;
    logic               r_fw_v;
    logic [BW-1:0]      r_fw_bin;
    logic [COUNT_W-1:0] r_fw_val;
    logic               w_hrd_pair;
    logic               w_hrd;
    logic [BW-1:0]      w_haddr;
    logic [COUNT_W-1:0] w_old, w_new;

    assign w_hrd_pair = r_d_v[BW-1] && r_d_ok[BW-1];
    assign w_hrd      = w_hrd_pair || (r_state == S_RO_RD);
    assign w_haddr    = (r_state == S_RO_RD) ? r_ro_bin : r_d_q[BW-1];

    // Forward the previous write: the read of this bin happened before it landed.
    always_comb begin
        if (r_fw_v && r_fw_bin == r_hw_bin) begin
            w_old = r_fw_val;
        end else begin
            w_old = r_hv_q ? r_hq : '0;
        end
        w_new = (w_old > 32'hFFFF_FFFD) ? 32'hFFFF_FFFF : w_old + COUNT_W'(2);
    end

    always_ff @(posedge i_clk) begin
        if (w_hrd) begin
            r_hq   <= r_hist[w_haddr];
            r_hv_q <= r_hv[w_haddr];
        end
        if (r_hw_v) begin
            r_hist[r_hw_bin] <= w_new;
        end
        r_hw_bin <= r_d_q[BW-1];
        r_fw_bin <= r_hw_bin;
        r_fw_val <= w_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv   <= '0;
            r_hw_v <= 1'b0;
            r_fw_v <= 1'b0;
        end else begin
            r_hw_v <= w_hrd_pair;
            r_fw_v <= r_hw_v;
            if (w_accept && w_op == OP_CLEAR) begin
                r_hv <= '0;
            end else if (r_hw_v) begin
                r_hv[r_hw_bin] <= 1'b1;
            end
        end
    end

    assign w_pipe_busy = r_p1_v || r_p2_v || r_p3_v || r_p4_v || w_sq.busy
                      || r_c_v || (|r_d_v) || r_hw_v;

    // ---------------- output slot ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == S_RO_WAIT && w_slot_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
        if (r_state == S_RO_WAIT && w_slot_free) begin
            o_bin_index <= BIN_OUT_W'(r_ro_bin);
            o_bin_count <= r_hv_q ? r_hq : '0;
            o_last_bin  <= (r_ro_bin == BW'(NUM_BINS - 1));
        end
    end

`ifndef SYNTHESIS
    a_idle_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_pipe_busy)
        else $error("input taken while pair pipeline still busy");

    a_drain_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && !w_pipe_busy) |=> (r_state == S_IDLE))
        else $error("drain did not return to idle");

    a_count_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("frame point count beyond store depth");
`endif

endmodule
